// ===== sv/point_in_rect_circle_hit_test_assert.svh =====
// Assertion macros for the point-in-figure hit test.
// Included by the top level; needs nothing else.
`ifndef POINT_IN_RECT_CIRCLE_HIT_TEST_ASSERT_SVH
`define POINT_IN_RECT_CIRCLE_HIT_TEST_ASSERT_SVH

// same-cycle implication
`define PRCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prch: assertion failed");

// next-cycle implication
`define PRCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prch: assertion failed");

`endif

// ===== sv/prch_pkg.sv =====
// Shared types, codes and helpers of the point-in-figure hit test.
// No dependencies.
package prch_pkg;

    localparam logic [1:0] MODE_RECT   = 2'd0;
    localparam logic [1:0] MODE_CIRCLE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam int FIG_INDEX_BITS = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = 1;

    typedef enum logic [1:0] {
        OP_RECT,
        OP_CIRCLE,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmd_ctrl;

    typedef struct packed {
        logic [FIG_INDEX_BITS-1:0] figure_index;
        logic                      matched;
        logic                      status;
        logic                      last;
    } t_result;

    // 1-based figure number, masked to the result field
    function automatic logic [FIG_INDEX_BITS-1:0] fig_index(input logic [31:0] idx0);
        logic [31:0] one_based;
        one_based = idx0 + 32'd1;
        return one_based[FIG_INDEX_BITS-1:0];
    endfunction

endpackage

// ===== sv/prch_in_if.sv =====
// Request channel into the hit test: mode and four coordinates.
// Stands alone.
interface prch_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;

    modport source (output valid, mode, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink   (input valid, mode, first_x, first_y, second_x, second_y,
                    output ready);
endinterface

// ===== sv/prch_out_if.sv =====
// Result channel out of the hit test.
// Stands alone.
interface prch_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] figure_index;
    logic       matched;
    logic       status;
    logic       last;

    modport source (output valid, figure_index, matched, status, last, input ready);
    modport sink   (input valid, figure_index, matched, status, last, output ready);
endinterface

// ===== sv/point_in_rect_circle_hit_test.sv =====
// Point-in-figure hit test, top level.
// Depends on prch_pkg, prch_in_if, prch_out_if, prch_front, prch_back and the assert header.
//
// Use: i_in takes requests (load rectangle, load circle, query point, clear),
// o_out gives results; both are valid/ready channels. A load or clear passes
// through the command queue into the result register. A query walks the table
// one figure per cycle, while the receiver keeps up, through a four-stage test
// pipe fed by the single read port of the figure table; the back end takes no
// new command until the scan has drained. Loads and clears run one per cycle
// while the result register is free. Each match gives one result, last set on
// the final one; no match gives a single result with last set. A load into a
// full table is dropped and answered with status set.
// Reset empties the table, the two-entry command queue and the result
// register; no clearing pass is needed. When the receiver stalls, the result
// is held, the scan freezes, the queue fills and i_in.ready then drops.
`include "point_in_rect_circle_hit_test_assert.svh"

module point_in_rect_circle_hit_test #(
    parameter int MAX_FIGURES = 16,
    parameter int COORD_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prch_in_if.sink     i_in,
    prch_out_if.source  o_out
);

    prch_pkg::t_cmd_ctrl          w_cmd;
    logic [4*COORD_BITS-1:0]      w_cmd_coords;
    logic                         w_cmd_pop;

    prch_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_cmd        (w_cmd),
        .o_cmd_coords (w_cmd_coords),
        .i_cmd_pop    (w_cmd_pop)
    );

    prch_back #(
        .MAX_FIGURES (MAX_FIGURES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_coords (w_cmd_coords),
        .o_cmd_pop    (w_cmd_pop),
        .o_out        (o_out)
    );

    `PRCH_ASSERT_IMP(a_pop_needs_cmd, i_clk, i_rst_n, w_cmd_pop, w_cmd.valid)
    `PRCH_ASSERT_NXT(a_query_blocks, i_clk, i_rst_n, w_cmd_pop && (w_cmd.op == prch_pkg::OP_QUERY), !w_cmd_pop)
    `PRCH_ASSERT_IMP(a_nomatch_last, i_clk, i_rst_n, o_out.valid && !o_out.matched, o_out.last)
    `PRCH_ASSERT_IMP(a_match_ok, i_clk, i_rst_n, o_out.valid && o_out.matched, !o_out.status)

endmodule

// ===== sv/prch_front.sv =====
// Front end: takes requests, decodes the mode and queues commands.
// Depends on prch_pkg and prch_in_if.
module prch_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    prch_in_if.sink                   i_in,
    output prch_pkg::t_cmd_ctrl       o_cmd,
    output logic [4*COORD_BITS-1:0]   o_cmd_coords,
    input  logic                      i_cmd_pop
);

    localparam int CW = 4 * COORD_BITS;

    prch_pkg::t_op                    r_op     [prch_pkg::QUEUE_DEPTH];
    logic [CW-1:0]                    r_coords [prch_pkg::QUEUE_DEPTH];
    logic [prch_pkg::QPTR_BITS-1:0]   r_wr_ptr;
    logic [prch_pkg::QPTR_BITS-1:0]   r_rd_ptr;
    logic [prch_pkg::QPTR_BITS:0]     r_fill;

    prch_pkg::t_op                    n_op;
    logic [CW-1:0]                    n_coords;
    logic                             push;

    always_comb begin
        unique case (i_in.mode)
            prch_pkg::MODE_RECT: begin
                n_op     = prch_pkg::OP_RECT;
                n_coords = {i_in.first_x, i_in.first_y, i_in.second_x, i_in.second_y};
            end
            prch_pkg::MODE_CIRCLE: begin
                n_op     = prch_pkg::OP_CIRCLE;
                n_coords = {i_in.first_x, i_in.first_y, i_in.second_x,
                            {COORD_BITS{1'b0}}};
            end
            prch_pkg::MODE_QUERY: begin
                n_op     = prch_pkg::OP_QUERY;
                n_coords = {i_in.first_x, i_in.first_y, {(2*COORD_BITS){1'b0}}};
            end
            prch_pkg::MODE_CLEAR: begin
                n_op     = prch_pkg::OP_CLEAR;
                n_coords = '0;
            end
        endcase
    end

    assign i_in.ready = (r_fill != (prch_pkg::QPTR_BITS+1)'(prch_pkg::QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr_ptr]     <= n_op;
            r_coords[r_wr_ptr] <= n_coords;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_cmd_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_cmd.valid  = (r_fill != '0);
    assign o_cmd.op     = r_op[r_rd_ptr];
    assign o_cmd_coords = r_coords[r_rd_ptr];

endmodule

// ===== sv/prch_back.sv =====
// Back end: figure table, pipelined scan and result register.
// Depends on prch_pkg and prch_out_if.
module prch_back #(
    parameter int MAX_FIGURES = 16,
    parameter int COORD_BITS  = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  prch_pkg::t_cmd_ctrl       i_cmd,
    input  logic [4*COORD_BITS-1:0]   i_cmd_coords,
    output logic                      o_cmd_pop,
    prch_out_if.source                o_out
);

    localparam int C    = COORD_BITS;
    localparam int IDXW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int CNTW = $clog2(MAX_FIGURES + 1);
    localparam int ENTW = 4 * C + 1;
    localparam int SQW  = 2 * (C - 1);
    localparam int SUMW = SQW + 1;

    // command fields
    logic signed [C-1:0] w_fx, w_fy;
    assign w_fx = i_cmd_coords[4*C-1 -: C];
    assign w_fy = i_cmd_coords[3*C-1 -: C];

    // control
    prch_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  r_scan;
    logic signed [C-1:0] r_qx, r_qy;
    logic             w_full, w_start, w_issue, w_issue_end, w_mem_we, w_adv;
    logic             w_idle_emit, w_d_emit, w_hit;
    prch_pkg::t_result w_idle_res, w_d_res;

    // figure table
    logic [ENTW-1:0]  mem [MAX_FIGURES];
    logic [IDXW-1:0]  w_rd_addr;

    // stage 1
    logic             r_s1_valid, r_s1_end;
    logic [IDXW-1:0]  r_s1_idx;
    logic [ENTW-1:0]  r_rd;
    // stage 2
    logic             r_s2_valid, r_s2_end, r_s2_circ, r_s2_rect_hit, r_s2_rpos;
    logic [IDXW-1:0]  r_s2_idx;
    logic [C-2:0]     r_s2_r;
    logic signed [C:0] r_s2_dx, r_s2_dy;
    // stage 3
    logic             r_s3_valid, r_s3_end, r_s3_circ, r_s3_rect_hit, r_s3_rpos;
    logic [IDXW-1:0]  r_s3_idx;
    logic [C-2:0]     r_s3_r;
    logic [C-1:0]     r_s3_adx, r_s3_ady;
    // stage 4
    logic             r_s4_valid, r_s4_end, r_s4_circ, r_s4_rect_hit, r_s4_near;
    logic [IDXW-1:0]  r_s4_idx;
    logic [SQW-1:0]   r_s4_sqx, r_s4_sqy, r_s4_sqr;

    // pending match and result register
    logic             r_pend_valid;
    logic [IDXW-1:0]  r_pend_idx;
    logic             r_out_valid;
    prch_pkg::t_result r_out;
    logic             w_out_free;

    assign w_full      = (r_count == CNTW'(MAX_FIGURES));
    assign w_issue_end = (r_scan >= r_count);
    assign w_rd_addr   = w_issue_end ? '0 : r_scan[IDXW-1:0];
    assign w_out_free  = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prch_pkg::ST_IDLE:  if (w_start) n_state = prch_pkg::ST_SCAN;
            prch_pkg::ST_SCAN:  if (w_issue && w_issue_end) n_state = prch_pkg::ST_DRAIN;
            prch_pkg::ST_DRAIN: if (r_s4_valid && r_s4_end && w_adv) begin
                n_state = prch_pkg::ST_IDLE;
            end
            default:            n_state = prch_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        w_start    = 1'b0;
        w_issue    = 1'b0;
        w_mem_we   = 1'b0;
        w_idle_emit = 1'b0;
        w_idle_res = '0;
        unique case (r_state)
            prch_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    priority if (i_cmd.op == prch_pkg::OP_QUERY) begin
                        o_cmd_pop = 1'b1;
                        w_start   = 1'b1;
                    end else if (w_out_free) begin
                        o_cmd_pop         = 1'b1;
                        w_idle_emit       = 1'b1;
                        w_idle_res.last   = 1'b1;
                        w_idle_res.status = (i_cmd.op != prch_pkg::OP_CLEAR) && w_full;
                        w_mem_we          = (i_cmd.op != prch_pkg::OP_CLEAR) && !w_full;
                    end
                end
            end
            prch_pkg::ST_SCAN:  w_issue = w_adv;
            prch_pkg::ST_DRAIN: w_issue = 1'b0;
            default:            w_issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prch_pkg::ST_IDLE;
            r_count <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && (i_cmd.op == prch_pkg::OP_CLEAR)) begin
                r_count <= '0;
            end else if (w_mem_we) begin
                r_count <= r_count + 1'b1;
            end
            if (w_start) begin
                r_scan <= '0;
            end else if (w_issue && !w_issue_end) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_qx <= w_fx;
            r_qy <= w_fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_count[IDXW-1:0]] <= {i_cmd.op == prch_pkg::OP_CIRCLE, i_cmd_coords};
        end
        if (w_adv) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    // stage 2 datapath
    logic              w_circ;
    logic signed [C-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [C:0] w_dx, w_dy;
    assign w_circ = r_rd[ENTW-1];
    assign w_ax   = r_rd[4*C-1 -: C];
    assign w_ay   = r_rd[3*C-1 -: C];
    assign w_bx   = r_rd[2*C-1 -: C];
    assign w_by   = r_rd[C-1:0];
    assign w_dx   = (C+1)'(r_qx) - (C+1)'(w_ax);
    assign w_dy   = (C+1)'(r_qy) - (C+1)'(w_ay);

    // stage 3 datapath
    logic signed [C:0] w_ndx, w_ndy;
    assign w_ndx = -r_s2_dx;
    assign w_ndy = -r_s2_dy;

    // stage 4 datapath
    logic [SQW-1:0] w_sqx, w_sqy, w_sqr;
    assign w_sqx = SQW'(r_s3_adx[C-2:0]) * SQW'(r_s3_adx[C-2:0]);
    assign w_sqy = SQW'(r_s3_ady[C-2:0]) * SQW'(r_s3_ady[C-2:0]);
    assign w_sqr = SQW'(r_s3_r) * SQW'(r_s3_r);

    // decision at the end of the pipe
    logic [SUMW-1:0] w_sum;
    assign w_sum = SUMW'(r_s4_sqx) + SUMW'(r_s4_sqy);
    assign w_hit = r_s4_circ ? (r_s4_near && (w_sum < SUMW'(r_s4_sqr))) : r_s4_rect_hit;

    assign w_adv = !(r_s4_valid && (r_s4_end || (w_hit && r_pend_valid))) || w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_end      <= w_issue_end;
            r_s1_idx      <= r_scan[IDXW-1:0];
            r_s2_end      <= r_s1_end;
            r_s2_idx      <= r_s1_idx;
            r_s2_circ     <= w_circ;
            r_s2_rect_hit <= (r_qx > w_ax) && (r_qx < w_bx) && (r_qy > w_by) && (r_qy < w_ay);
            r_s2_rpos     <= !w_bx[C-1] && (w_bx != '0);
            r_s2_r        <= w_bx[C-2:0];
            r_s2_dx       <= w_dx;
            r_s2_dy       <= w_dy;
            r_s3_end      <= r_s2_end;
            r_s3_idx      <= r_s2_idx;
            r_s3_circ     <= r_s2_circ;
            r_s3_rect_hit <= r_s2_rect_hit;
            r_s3_rpos     <= r_s2_rpos;
            r_s3_r        <= r_s2_r;
            r_s3_adx      <= r_s2_dx[C] ? w_ndx[C-1:0] : r_s2_dx[C-1:0];
            r_s3_ady      <= r_s2_dy[C] ? w_ndy[C-1:0] : r_s2_dy[C-1:0];
            r_s4_end      <= r_s3_end;
            r_s4_idx      <= r_s3_idx;
            r_s4_circ     <= r_s3_circ;
            r_s4_rect_hit <= r_s3_rect_hit;
            r_s4_near     <= r_s3_rpos && (r_s3_adx < {1'b0, r_s3_r})
                                       && (r_s3_ady < {1'b0, r_s3_r});
            r_s4_sqx      <= w_sqx;
            r_s4_sqy      <= w_sqy;
            r_s4_sqr      <= w_sqr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // a match is held back until the next one or the end of the scan sets its last flag
    always_comb begin
        w_d_emit = 1'b0;
        w_d_res  = '0;
        if (r_s4_valid && w_adv) begin
            if (r_s4_end) begin
                w_d_emit     = 1'b1;
                w_d_res.last = 1'b1;
                if (r_pend_valid) begin
                    w_d_res.figure_index = prch_pkg::fig_index(32'(r_pend_idx));
                    w_d_res.matched      = 1'b1;
                end
            end else if (w_hit && r_pend_valid) begin
                w_d_emit             = 1'b1;
                w_d_res.figure_index = prch_pkg::fig_index(32'(r_pend_idx));
                w_d_res.matched      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (r_s4_valid && w_adv) begin
            if (r_s4_end) begin
                r_pend_valid <= 1'b0;
            end else if (w_hit) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_valid && w_adv && !r_s4_end && w_hit) begin
            r_pend_idx <= r_s4_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_idle_emit || w_d_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_idle_emit) begin
            r_out <= w_idle_res;
        end else if (w_d_emit) begin
            r_out <= w_d_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.figure_index = r_out.figure_index;
    assign o_out.matched      = r_out.matched;
    assign o_out.status       = r_out.status;
    assign o_out.last         = r_out.last;

endmodule

// ===== bench/point_in_rect_circle_hit_test_test.sv =====
// Testbench for the point-in-figure hit test: directed and random requests with
// random idling on both channels, results checked against an in-bench predictor.
// Depends on prch_pkg, prch_in_if, prch_out_if and point_in_rect_circle_hit_test.
`timescale 1ns / 100ps

module point_in_rect_circle_hit_test_test;

    localparam int COORD_BITS      = 24;
    localparam int FIGURE_SLOTS    = 16;
    localparam int RANDOM_REQUESTS = 420;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int COORD_MAX       = 8388607;
    localparam int COORD_MIN       = -8388608;

    logic clk;
    logic rst_n;

    prch_in_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    prch_out_if res_ch ();

    point_in_rect_circle_hit_test #(
        .MAX_FIGURES(FIGURE_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    // predicted figure table
    int                           fig_count;
    logic                         fig_circle [FIGURE_SLOTS];
    logic signed [COORD_BITS-1:0] fig_ax     [FIGURE_SLOTS];
    logic signed [COORD_BITS-1:0] fig_ay     [FIGURE_SLOTS];
    logic signed [COORD_BITS-1:0] fig_bx     [FIGURE_SLOTS];
    logic signed [COORD_BITS-1:0] fig_by     [FIGURE_SLOTS];

    prch_pkg::t_result expected_results[$];
    int      mismatches    = 0;
    int      requests_sent = 0;
    int      cycle_count   = 0;
    int      hold_request  = 0;
    bit      idle_on       = 1'b1;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit figure_holds_point(input int k,
                                              input logic signed [COORD_BITS-1:0] x,
                                              input logic signed [COORD_BITS-1:0] y);
        longint radius, dx, dy;
        if (!fig_circle[k])
            return x > fig_ax[k] && x < fig_bx[k] && y > fig_by[k] && y < fig_ay[k];
        radius = longint'(fig_bx[k]);
        if (radius <= 0)
            return 1'b0;
        dx = longint'(x) - longint'(fig_ax[k]);
        dy = longint'(y) - longint'(fig_ay[k]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= radius || dy >= radius)
            return 1'b0;
        return dx * dx + dy * dy < radius * radius;
    endfunction

    task automatic push_result(input int index, input bit hit, input bit full,
                               input bit final_one);
        prch_pkg::t_result r;
        r.figure_index = index[4:0];
        r.matched      = hit;
        r.status       = full;
        r.last         = final_one;
        expected_results = {expected_results, r};
    endtask

    task automatic predict_results(input logic [1:0] mode,
                                   input logic signed [COORD_BITS-1:0] fx, fy, sx, sy);
        int hits;
        hits = 0;
        case (mode)
            prch_pkg::MODE_CLEAR: begin
                fig_count = 0;
                push_result(0, 1'b0, 1'b0, 1'b1);
            end
            prch_pkg::MODE_RECT, prch_pkg::MODE_CIRCLE: begin
                if (fig_count >= FIGURE_SLOTS) begin
                    push_result(0, 1'b0, 1'b1, 1'b1);
                end else begin
                    fig_circle[fig_count] = (mode == prch_pkg::MODE_CIRCLE);
                    fig_ax[fig_count]     = fx;
                    fig_ay[fig_count]     = fy;
                    fig_bx[fig_count]     = sx;
                    fig_by[fig_count]     = (mode == prch_pkg::MODE_CIRCLE) ? '0 : sy;
                    fig_count++;
                    push_result(0, 1'b0, 1'b0, 1'b1);
                end
            end
            default: begin
                for (int k = 0; k < fig_count; k++) begin
                    if (figure_holds_point(k, fx, fy)) begin
                        push_result(k + 1, 1'b1, 1'b0, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    push_result(0, 1'b0, 1'b0, 1'b1);
                else
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    // valid stays high across back-to-back requests; only one NBA per step
    task automatic send_request(input logic [1:0] mode, input int fx, fy, sx, sy);
        int gap;
        logic signed [COORD_BITS-1:0] c_fx, c_fy, c_sx, c_sy;
        c_fx = fx[COORD_BITS-1:0];
        c_fy = fy[COORD_BITS-1:0];
        c_sx = sx[COORD_BITS-1:0];
        c_sy = sy[COORD_BITS-1:0];
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.first_x  <= c_fx;
        req_ch.first_y  <= c_fy;
        req_ch.second_x <= c_sx;
        req_ch.second_y <= c_sy;
        do @(posedge clk); while (!req_ch.ready);
        predict_results(mode, c_fx, c_fy, c_sx, c_sy);
        requests_sent++;
    endtask

    task automatic check_result();
        prch_pkg::t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result index %0d matched %0b status %0b last %0b",
                     $time, res_ch.figure_index, res_ch.matched, res_ch.status,
                     res_ch.last);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (res_ch.figure_index !== want.figure_index) begin
            $display("%0t: figure_index expected %0d got %0d",
                     $time, want.figure_index, res_ch.figure_index);
            mismatches++;
        end
        if (res_ch.matched !== want.matched) begin
            $display("%0t: matched expected %0b got %0b", $time, want.matched, res_ch.matched);
            mismatches++;
        end
        if (res_ch.status !== want.status) begin
            $display("%0t: status expected %0b got %0b", $time, want.status, res_ch.status);
            mismatches++;
        end
        if (res_ch.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, res_ch.last);
            mismatches++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_checker
        int wait_cycles;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end else begin
                wait_cycles = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (wait_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            check_result();
        end
    end

    function automatic int coord_at_scale(input int scale);
        return int'($urandom_range(0, (2 << scale) - 1)) - (1 << scale);
    endfunction

    task automatic test_empty_table();
        send_request(prch_pkg::MODE_QUERY, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_CLEAR, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_QUERY, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    endtask

    task automatic test_rectangles();
        send_request(prch_pkg::MODE_CLEAR, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_RECT, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_request(prch_pkg::MODE_RECT, 0, 256, 256, 0);
        send_request(prch_pkg::MODE_RECT, 256, 256, 256, 0);
        send_request(prch_pkg::MODE_RECT, 0, 0, 256, 256);
        send_request(prch_pkg::MODE_QUERY, 128, 128, 0, 0);
        send_request(prch_pkg::MODE_QUERY, 0, 128, 0, 0);
        send_request(prch_pkg::MODE_QUERY, COORD_MIN, 0, 0, 0);
        send_request(prch_pkg::MODE_QUERY, COORD_MAX, COORD_MAX, 0, 0);
    endtask

    task automatic test_circles();
        send_request(prch_pkg::MODE_CLEAR, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_CIRCLE, 0, 0, 512, COORD_MAX);
        send_request(prch_pkg::MODE_CIRCLE, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_CIRCLE, 0, 0, COORD_MIN, 0);
        send_request(prch_pkg::MODE_CIRCLE, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_request(prch_pkg::MODE_QUERY, 511, 0, 0, 0);
        send_request(prch_pkg::MODE_QUERY, 512, 0, 0, 0);
        send_request(prch_pkg::MODE_QUERY, 362, 362, 0, 0);
        send_request(prch_pkg::MODE_QUERY, 363, 362, 0, 0);
        send_request(prch_pkg::MODE_QUERY, COORD_MAX, COORD_MIN, 0, 0);
    endtask

    // table filled while results are held off, so the input stalls
    task automatic test_full_table_backpressure();
        idle_on      = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        send_request(prch_pkg::MODE_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < FIGURE_SLOTS; k++) begin
            if (k % 2 == 0)
                send_request(prch_pkg::MODE_RECT, COORD_MIN, COORD_MAX, COORD_MAX,
                             COORD_MIN);
            else
                send_request(prch_pkg::MODE_CIRCLE, 0, 0, COORD_MAX, 0);
        end
        send_request(prch_pkg::MODE_QUERY, 0, 0, 0, 0);
        send_request(prch_pkg::MODE_CIRCLE, 0, 0, 5, 0);
        send_request(prch_pkg::MODE_QUERY, COORD_MIN, 0, 0, 0);
        idle_on = 1'b1;
    endtask

    task automatic load_random_figure(input int scale);
        int x0, y0, ext_x, ext_y, radius;
        bit broad;
        x0    = coord_at_scale(scale);
        y0    = coord_at_scale(scale);
        ext_x = $urandom_range(0, 1 << scale);
        ext_y = $urandom_range(0, 1 << scale);
        broad = ($urandom_range(0, 3) == 0);
        if (broad) begin
            x0    = -(1 << scale);
            y0    = x0;
            ext_x = (2 << scale) - 1;
            ext_y = ext_x;
        end
        if ($urandom_range(0, 1) == 1) begin
            radius = (ext_x > COORD_MAX) ? COORD_MAX : ext_x;
            if (broad) begin
                x0 = 0;
                y0 = 0;
            end
            if ($urandom_range(0, 7) == 0)
                radius = -radius - 1;
            else if ($urandom_range(0, 15) == 0)
                radius = 0;
            send_request(prch_pkg::MODE_CIRCLE, x0, y0, radius, $urandom);
        end else if ($urandom_range(0, 9) == 0) begin
            send_request(prch_pkg::MODE_RECT, x0, y0, x0 + ext_x, y0 + ext_y);
        end else begin
            send_request(prch_pkg::MODE_RECT, x0, y0 + ext_y, x0 + ext_x, y0);
        end
    endtask

    task automatic query_random_point(input int scale);
        int k, x, y;
        if (fig_count > 0 && $urandom_range(0, 3) == 0) begin
            // aim at the boundary of a stored figure
            k = $urandom_range(0, fig_count - 1);
            x = ($urandom_range(0, 1) ? fig_ax[k] : fig_bx[k]) + $urandom_range(0, 2) - 1;
            y = ($urandom_range(0, 1) ? fig_ay[k] : fig_by[k]) + $urandom_range(0, 2) - 1;
        end else begin
            x = coord_at_scale(scale);
            y = coord_at_scale(scale);
        end
        send_request(prch_pkg::MODE_QUERY, x, y, $urandom, $urandom);
    endtask

    task automatic test_random_sequences();
        int scales[4] = '{4, 10, 16, 23};
        int start, scale;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                 $urandom);
            end else begin
                scale = scales[$urandom_range(0, 3)];
                if ($urandom_range(0, 3) != 0)
                    send_request(prch_pkg::MODE_CLEAR, $urandom, $urandom, $urandom,
                                 $urandom);
                repeat ($urandom_range(1, 20))
                    load_random_figure(scale);
                repeat ($urandom_range(2, 8))
                    query_random_point(scale);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : main_sequence
        fig_count       = 0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= prch_pkg::MODE_CLEAR;
        req_ch.first_x  <= '0;
        req_ch.first_y  <= '0;
        req_ch.second_x <= '0;
        req_ch.second_y <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_rectangles();
        test_circles();
        test_full_table_backpressure();
        test_random_sequences();

        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/prch_pkg.sv
sv/prch_in_if.sv
sv/prch_out_if.sv
sv/prch_front.sv
sv/prch_back.sv
sv/point_in_rect_circle_hit_test.sv
bench/point_in_rect_circle_hit_test_test.sv
